// ===== hdl/mhd_pkg.sv =====
package mhd_pkg;

  // Header layout
  localparam int HDR_LEN    = 26;
  localparam int CNT_W      = 17;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Accepted message type range
  localparam logic [7:0] TYPE_LO = 8'h34;
  localparam logic [7:0] TYPE_HI = 8'h43;

  // Verdict codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LAYOUT  = 2'd1,
    ST_VERSION = 2'd2,
    ST_PARAM   = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_VERSION  = 2'd0,
    CFG_MAX_LEN  = 2'd1,
    CFG_CHAN     = 2'd2,
    CFG_RESERVED = 2'd3
  } cfg_addr_t;

  // One front-to-back word: up to two results sharing the header snapshot
  typedef struct packed {
    logic        has_body;
    logic        has_verdict;
    logic [7:0]  body;
    status_t     status;
    logic [7:0]  msg_type;
    logic [31:0] request;
    logic [31:0] generation;
    logic [63:0] cookie;
    logic [15:0] length;
  } entry_t;

  // Expected magic byte at header offsets 0..3
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h4E;
      2'd1:    m = 8'h43;
      2'd2:    m = 8'h4C;
      default: m = 8'h31;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/mhd_if.sv =====
// Payload byte channel
interface mhd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_payload;
  logic [7:0] carrier_type;

  modport source (output valid, data_byte, end_of_payload, carrier_type, input ready);
  modport sink   (input valid, data_byte, end_of_payload, carrier_type, output ready);
endinterface

// Result channel
interface mhd_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  body_byte;
  logic [7:0]  frame_type;
  logic [31:0] request_ident;
  logic [31:0] generation;
  logic [63:0] cookie;
  logic [15:0] body_length;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, kind, body_byte, frame_type, request_ident, generation,
                  cookie, body_length, status, last, input ready);
  modport sink   (input valid, kind, body_byte, frame_type, request_ident, generation,
                  cookie, body_length, status, last, output ready);
endinterface

// Configuration write channel
interface mhd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== hdl/mhd_front.sv =====
module mhd_front (
  input  logic            clk,
  input  logic            rst,
  mhd_byte_if.sink        payload,
  mhd_cfg_if.sink         cfg,
  input  logic            q_ready,
  output logic            q_push,
  output mhd_pkg::entry_t q_entry
);
  import mhd_pkg::*;

  logic [7:0]       expected_version;
  logic [15:0]      max_body_length;
  logic [7:0]       data_channel_type;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  status_t          first_error, first_error_next;
  logic [7:0]       latched_carrier, latched_carrier_next;
  logic [7:0]       type_reg, type_reg_next;
  logic [31:0]      request_reg, request_reg_next;
  logic [31:0]      generation_reg, generation_reg_next;
  logic [63:0]      cookie_reg, cookie_reg_next;
  logic [15:0]      length_reg, length_reg_next;

  logic             accept;
  logic [4:0]       hp;
  logic [7:0]       b;
  logic             in_hdr;
  logic             fail;
  status_t          fail_code;
  logic             body_ok;
  status_t          verdict;
  logic [15:0]      len_full;

  // Nothing is taken while reset is held
  assign cfg.ready     = !rst;
  assign payload.ready = q_ready & !rst;
  assign accept        = payload.valid & q_ready & !rst;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version  <= 8'd1;
      max_body_length   <= 16'd1024;
      data_channel_type <= 8'd1;
    end else if (cfg.valid) begin
      case (cfg_addr_t'(cfg.addr))
        CFG_VERSION: expected_version  <= cfg.wdata[7:0];
        CFG_MAX_LEN: max_body_length   <= cfg.wdata;
        CFG_CHAN:    data_channel_type <= cfg.wdata[7:0];
        default: ;
      endcase
    end
  end

  // Header parse and checks for the byte on offer
  always_comb begin
    b                    = payload.data_byte;
    hp                   = byte_count[4:0];
    in_hdr               = byte_count < CNT_W'(HDR_LEN);
    latched_carrier_next = (byte_count == '0) ? payload.carrier_type : latched_carrier;
    type_reg_next        = type_reg;
    request_reg_next     = request_reg;
    generation_reg_next  = generation_reg;
    cookie_reg_next      = cookie_reg;
    length_reg_next      = length_reg;
    len_full             = {length_reg[15:8], b};
    fail                 = 1'b0;
    fail_code            = ST_LAYOUT;

    if (in_hdr) begin
      if (hp < 5'd4) begin
        fail = (b != magic_byte(hp[1:0]));
      end else if (hp == 5'd4) begin
        fail      = (b != expected_version);
        fail_code = ST_VERSION;
      end else if (hp == 5'd5) begin
        type_reg_next = b;
        fail = (b < TYPE_LO) || (b > TYPE_HI) ||
               ((latched_carrier != 8'd0) && (latched_carrier != data_channel_type));
      end else if (hp < 5'd8) begin
        fail = (b != 8'd0);
      end else if (hp < 5'd12) begin
        request_reg_next[8*(3-hp[1:0]) +: 8] = b;
      end else if (hp < 5'd16) begin
        generation_reg_next[8*(3-hp[1:0]) +: 8] = b;
      end else if (hp < 5'd24) begin
        cookie_reg_next[8*(7-hp[2:0]) +: 8] = b;
      end else if (hp == 5'd24) begin
        length_reg_next[15:8] = b;
      end else begin
        length_reg_next = len_full;
        fail = (len_full == 16'd0) || (len_full > max_body_length);
      end
    end

    first_error_next = (fail && first_error == ST_OK) ? fail_code : first_error;

    // Body byte passes while the header is clean and within the declared length
    body_ok = !in_hdr && (first_error == ST_OK) &&
              ((byte_count - CNT_W'(HDR_LEN)) < CNT_W'(length_reg));

    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;

    // End-of-message verdict
    if (byte_count_next < CNT_W'(HDR_LEN)) begin
      verdict = ST_LAYOUT;
    end else if (first_error_next != ST_OK) begin
      verdict = first_error_next;
    end else if (byte_count_next != CNT_W'(HDR_LEN) + CNT_W'(length_reg_next)) begin
      verdict = ST_LAYOUT;
    end else if (request_reg_next == 32'd0) begin
      verdict = ST_PARAM;
    end else begin
      verdict = ST_OK;
    end

    q_entry.has_body    = body_ok;
    q_entry.has_verdict = payload.end_of_payload;
    q_entry.body        = b;
    q_entry.status      = verdict;
    q_entry.msg_type    = type_reg_next;
    q_entry.request     = request_reg_next;
    q_entry.generation  = generation_reg_next;
    q_entry.cookie      = cookie_reg_next;
    q_entry.length      = length_reg_next;
    q_push              = accept && (body_ok || payload.end_of_payload);
  end

  // Message state; cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst || (accept && payload.end_of_payload)) begin
      byte_count      <= '0;
      first_error     <= ST_OK;
      latched_carrier <= '0;
      type_reg        <= '0;
      request_reg     <= '0;
      generation_reg  <= '0;
      cookie_reg      <= '0;
      length_reg      <= '0;
    end else if (accept) begin
      byte_count      <= byte_count_next;
      first_error     <= first_error_next;
      latched_carrier <= latched_carrier_next;
      type_reg        <= type_reg_next;
      request_reg     <= request_reg_next;
      generation_reg  <= generation_reg_next;
      cookie_reg      <= cookie_reg_next;
      length_reg      <= length_reg_next;
    end
  end

endmodule

// ===== hdl/mhd_queue.sv =====
module mhd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mhd_pkg::entry_t push_entry,
  output logic            push_ready,
  output logic            pop_valid,
  output mhd_pkg::entry_t pop_entry,
  input  logic            pop
);
  import mhd_pkg::*;

  entry_t     slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = slot[rd_ptr];

  // Two-word queue between parser and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_entry;
  end

endmodule

// ===== hdl/mhd_back.sv =====
module mhd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mhd_pkg::entry_t q_entry,
  output logic            q_pop,
  mhd_res_if.source       result
);
  import mhd_pkg::*;

  logic    out_valid;
  logic    half;
  logic    load;
  logic    emit_body;

  logic        kind;
  logic [7:0]  body_byte;
  logic [7:0]  frame_type;
  logic [31:0] request_ident;
  logic [31:0] generation;
  logic [63:0] cookie;
  logic [15:0] body_length;
  status_t     status;
  logic        last;

  // Output register free or being drained this cycle
  assign load      = q_valid && (!out_valid || result.ready);
  assign emit_body = q_entry.has_body && !half;
  assign q_pop     = load && !(emit_body && q_entry.has_verdict);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        half      <= emit_body && q_entry.has_verdict;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word: body byte first, verdict after it
  always_ff @(posedge clk) begin
    if (load) begin
      kind          <= !emit_body;
      body_byte     <= emit_body ? q_entry.body : 8'd0;
      status        <= emit_body ? ST_OK : q_entry.status;
      last          <= !(emit_body && q_entry.has_verdict);
      frame_type    <= q_entry.msg_type;
      request_ident <= q_entry.request;
      generation    <= q_entry.generation;
      cookie        <= q_entry.cookie;
      body_length   <= q_entry.length;
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = kind;
  assign result.body_byte     = body_byte;
  assign result.frame_type    = frame_type;
  assign result.request_ident = request_ident;
  assign result.generation    = generation;
  assign result.cookie        = cookie;
  assign result.body_length   = body_length;
  assign result.status        = status;
  assign result.last          = last;

endmodule

// ===== hdl/message_header_deframer_unit.sv =====
// Channel   Dir  Word
// payload   in   data_byte, end_of_payload, carrier_type
// cfg       in   addr (register index), wdata
// result    out  kind, body_byte, frame_type, request_ident, generation,
//                cookie, body_length, status, last
//
// One payload byte is taken per cycle unless the queue is full; the parser does
// one counter compare and one field insert per byte. A byte that ends the payload
// inside the body gives two result words, body byte first, then the verdict.
// A two-word queue separates parser and output, so either side may stall alone.
// Synchronous reset restores register defaults and clears the message state;
// no word is taken while it is held.
module message_header_deframer_unit (
  input  logic      clk,
  input  logic      rst,
  mhd_byte_if.sink  payload,
  mhd_cfg_if.sink   cfg,
  mhd_res_if.source result
);
  import mhd_pkg::*;

  logic   push;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop;
  entry_t pop_entry;

  mhd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .payload (payload),
    .cfg     (cfg),
    .q_ready (push_ready),
    .q_push  (push),
    .q_entry (push_entry)
  );

  mhd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop)
  );

  mhd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_entry (pop_entry),
    .q_pop   (pop),
    .result  (result)
  );

endmodule

// ===== tb/tb_message_header_deframer_unit.sv =====
module tb_message_header_deframer_unit;
  import mhd_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_WORDS  = 16;

  // Magic bytes at header offsets 0..3, first byte in the top slot
  localparam logic [31:0] MAGIC_WORD = 32'h4E43_4C31;

  // Header flaws, one bit each, so that several can be combined
  localparam int FL_NONE     = 0;
  localparam int FL_SHORT    = 1 << 0;
  localparam int FL_MAGIC    = 1 << 1;
  localparam int FL_VERSION  = 1 << 2;
  localparam int FL_TYPE     = 1 << 3;
  localparam int FL_BINDING  = 1 << 4;
  localparam int FL_FLAGS    = 1 << 5;
  localparam int FL_LEN_ZERO = 1 << 6;
  localparam int FL_LEN_BIG  = 1 << 7;
  localparam int FL_EXTRA    = 1 << 8;
  localparam int FL_FEWER    = 1 << 9;
  localparam int FL_REQ_ZERO = 1 << 10;
  localparam int FL_KINDS    = 11;

  typedef enum int {
    FILL_RAND,
    FILL_ONES,
    FILL_ZEROS
  } fill_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body;
    logic [7:0]  mtype;
    logic [31:0] req;
    logic [31:0] gen;
    logic [63:0] cookie;
    logic [15:0] blen;
    status_t     status;
    logic        last;
  } res_word_t;

  typedef struct {
    int      flaws;
    int      decl_len;
    int      short_len;
    fill_t   fill;
    bit      typed;
    status_t want;
  } msg_row_t;

  localparam int N_ROWS = 20;

  // Directed messages at reset settings; the typed verdicts are plain to see
  msg_row_t msg_rows [0:N_ROWS-1] = '{
    '{FL_NONE,                 1,    0,  FILL_RAND,  1'b1, ST_OK},
    '{FL_NONE,                 2,    0,  FILL_ONES,  1'b1, ST_OK},
    '{FL_NONE,                 2,    0,  FILL_ZEROS, 1'b1, ST_OK},
    '{FL_SHORT,                1,    1,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_SHORT,                1,    25, FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_SHORT | FL_VERSION,   1,    12, FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_MAGIC,                1,    0,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_VERSION,              1,    0,  FILL_RAND,  1'b1, ST_VERSION},
    '{FL_TYPE,                 1,    0,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_BINDING,              1,    0,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_FLAGS,                1,    0,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_LEN_ZERO,             1,    0,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_LEN_BIG,              1,    0,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_EXTRA,                1,    0,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_FEWER,                1,    0,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_REQ_ZERO,             1,    0,  FILL_RAND,  1'b1, ST_PARAM},
    '{FL_REQ_ZERO | FL_EXTRA,  1,    0,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_MAGIC | FL_VERSION,   1,    0,  FILL_RAND,  1'b1, ST_LAYOUT},
    '{FL_VERSION | FL_TYPE,    1,    0,  FILL_RAND,  1'b1, ST_VERSION},
    '{FL_VERSION | FL_REQ_ZERO, 1,   0,  FILL_RAND,  1'b1, ST_VERSION}
  };

  logic clk = 1'b0;
  logic rst;

  mhd_byte_if pl_if ();
  mhd_cfg_if  cfg_if ();
  mhd_res_if  res_if ();

  message_header_deframer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .payload (pl_if),
    .cfg     (cfg_if),
    .result  (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register shadow
  logic [7:0]  cf_version;
  logic [15:0] cf_maxlen;
  logic [7:0]  cf_chan;

  // Parser shadow
  logic [CNT_W-1:0] pr_count;
  status_t          pr_err;
  logic [7:0]       pr_carrier;
  logic [7:0]       pr_type;
  logic [31:0]      pr_req;
  logic [31:0]      pr_gen;
  logic [63:0]      pr_cookie;
  logic [15:0]      pr_len;

  res_word_t   awaited_words [$];
  logic [7:0]  msg_bytes [$];
  logic [7:0]  msg_carrier;

  int mismatches   = 0;
  int words_sent   = 0;
  int cycles       = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int res_stall    = 0;

  function automatic int draw_wait(input int pct);
    return ($urandom_range(0, 99) < pct) ? int'($urandom_range(0, 19)) : 0;
  endfunction

  // Picks an idling regime: none, some or every word
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 3);
    return (r == 0) ? 0 : (r == 1) ? 60 : 100;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
  endtask

  // ---------------------------------------------------------------------------
  // Deframer prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_parser();
    pr_count   = '0;
    pr_err     = ST_OK;
    pr_carrier = '0;
    pr_type    = '0;
    pr_req     = '0;
    pr_gen     = '0;
    pr_cookie  = '0;
    pr_len     = '0;
  endfunction

  function automatic void note_error(input status_t code);
    if (pr_err == ST_OK)
      pr_err = code;
  endfunction

  function automatic void push_word(input logic kind, input logic [7:0] body,
                                    input status_t st, input logic last);
    res_word_t w;
    w.kind   = kind;
    w.body   = body;
    w.mtype  = pr_type;
    w.req    = pr_req;
    w.gen    = pr_gen;
    w.cookie = pr_cookie;
    w.blen   = pr_len;
    w.status = st;
    w.last   = last;
    awaited_words.push_back(w);
  endfunction

  function automatic void parse_header(input int pos, input logic [7:0] b);
    if (pos < 4) begin
      if (b != MAGIC_WORD[8*(3-pos) +: 8])
        note_error(ST_LAYOUT);
    end else if (pos == 4) begin
      if (b != cf_version)
        note_error(ST_VERSION);
    end else if (pos == 5) begin
      pr_type = b;
      if (b < TYPE_LO || b > TYPE_HI)
        note_error(ST_LAYOUT);
      else if (pr_carrier != 8'd0 && pr_carrier != cf_chan)
        note_error(ST_LAYOUT);
    end else if (pos < 8) begin
      if (b != 8'd0)
        note_error(ST_LAYOUT);
    end else if (pos < 12) begin
      pr_req[8*(11-pos) +: 8] = b;
    end else if (pos < 16) begin
      pr_gen[8*(15-pos) +: 8] = b;
    end else if (pos < 24) begin
      pr_cookie[8*(23-pos) +: 8] = b;
    end else begin
      pr_len[8*(25-pos) +: 8] = b;
      if (pos == 25 && (pr_len == 16'd0 || pr_len > cf_maxlen))
        note_error(ST_LAYOUT);
    end
  endfunction

  // Expected results of one accepted payload word
  function automatic void deframe_word(input logic [7:0] b, input logic eop,
                                       input logic [7:0] carrier);
    int      pos;
    int      cnt;
    status_t st;
    pos = int'(pr_count);
    if (pos == 0)
      pr_carrier = carrier;
    if (pos < HDR_LEN)
      parse_header(pos, b);
    else if (pr_err == ST_OK && (pos - HDR_LEN) < int'(pr_len))
      push_word(1'b0, b, ST_OK, !eop);
    if (pr_count != COUNT_MAX)
      pr_count++;
    if (eop) begin
      cnt = int'(pr_count);
      if (cnt < HDR_LEN)
        st = ST_LAYOUT;
      else if (pr_err != ST_OK)
        st = pr_err;
      else if (cnt != HDR_LEN + int'(pr_len))
        st = ST_LAYOUT;
      else if (pr_req == 32'd0)
        st = ST_PARAM;
      else
        st = ST_OK;
      push_word(1'b1, 8'd0, st, 1'b1);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_addr_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.wdata <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_VERSION: cf_version = value[7:0];
      CFG_MAX_LEN: cf_maxlen  = value;
      CFG_CHAN:    cf_chan    = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_word(input logic [7:0] b, input logic eop, input logic [7:0] carrier);
    int gap;
    gap = draw_wait(snd_idle_pct);
    @(negedge clk);
    repeat (gap) begin
      pl_if.valid <= 1'b0;
      @(negedge clk);
    end
    pl_if.valid          <= 1'b1;
    pl_if.data_byte      <= b;
    pl_if.end_of_payload <= eop;
    pl_if.carrier_type   <= carrier;
    do @(posedge clk); while (!pl_if.ready);
    deframe_word(b, eop, carrier);
    words_sent++;
  endtask

  // Sends the built payload; carrier_type only matters on the first word
  task automatic send_message(input bit typed, input status_t want);
    int n;
    n = msg_bytes.size();
    for (int i = 0; i < n; i++)
      send_word(msg_bytes[i], i == n - 1, (i == 0) ? msg_carrier : 8'($urandom));
    if (typed)
      awaited_words[$].status = want;
    @(negedge clk);
    pl_if.valid <= 1'b0;
  endtask

  // Builds a header plus body, then spoils it as the flaw bits say
  task automatic build_message(input int flaws, input int decl_len, input int short_len,
                               input fill_t fill);
    logic [7:0]  hdr [0:HDR_LEN-1];
    logic [31:0] req;
    logic [31:0] gen;
    logic [63:0] ck;
    logic [7:0]  typ;
    logic [7:0]  t;
    logic [15:0] len;
    int          body_cnt;
    int          room;
    req = $urandom;
    if (req == 32'd0)
      req = 32'd1;
    gen = $urandom;
    ck  = {$urandom, $urandom};
    typ = 8'($urandom_range(int'(TYPE_LO), int'(TYPE_HI)));
    if (fill == FILL_ONES) begin
      req = '1;
      gen = '1;
      ck  = '1;
      typ = TYPE_HI;
    end else if (fill == FILL_ZEROS) begin
      req = 32'd1;
      gen = '0;
      ck  = '0;
      typ = TYPE_LO;
    end
    if (flaws & FL_REQ_ZERO)
      req = '0;

    len      = 16'(decl_len);
    body_cnt = decl_len;
    if (flaws & FL_LEN_ZERO) begin
      len      = 16'd0;
      body_cnt = $urandom_range(0, 4);
    end else if (flaws & FL_LEN_BIG) begin
      room = 65535 - int'(cf_maxlen);
      if (room == 0)
        len = 16'd0;
      else
        len = cf_maxlen + 16'($urandom_range(1, (room < 50) ? room : 50));
      body_cnt = $urandom_range(0, 6);
    end
    if (flaws & FL_EXTRA)
      body_cnt += $urandom_range(1, 5);
    if ((flaws & FL_FEWER) && body_cnt > 0)
      body_cnt = $urandom_range(0, body_cnt - 1);

    for (int k = 0; k < 4; k++)
      hdr[k] = MAGIC_WORD[8*(3-k) +: 8];
    hdr[4] = cf_version;
    hdr[5] = typ;
    hdr[6] = 8'd0;
    hdr[7] = 8'd0;
    for (int k = 0; k < 4; k++) begin
      hdr[8+k]  = req[8*(3-k) +: 8];
      hdr[12+k] = gen[8*(3-k) +: 8];
    end
    for (int k = 0; k < 8; k++)
      hdr[16+k] = ck[8*(7-k) +: 8];
    hdr[24] = len[15:8];
    hdr[25] = len[7:0];

    if (flaws & FL_MAGIC)
      hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    if (flaws & FL_VERSION)
      hdr[4] ^= 8'($urandom_range(1, 255));
    if (flaws & FL_TYPE) begin
      do t = 8'($urandom); while (t >= TYPE_LO && t <= TYPE_HI);
      hdr[5] = t;
    end
    if (flaws & FL_FLAGS)
      hdr[6 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));

    // Carrier: zero or the data channel type pass the binding check
    if (flaws & FL_BINDING) begin
      do t = 8'($urandom_range(1, 255)); while (t == cf_chan);
      msg_carrier = t;
    end else begin
      msg_carrier = $urandom_range(0, 1) ? cf_chan : 8'd0;
    end

    msg_bytes.delete();
    for (int k = 0; k < HDR_LEN; k++)
      msg_bytes.push_back(hdr[k]);
    for (int k = 0; k < body_cnt; k++)
      msg_bytes.push_back((fill == FILL_ONES) ? 8'hFF :
                          (fill == FILL_ZEROS) ? 8'h00 : 8'($urandom));
    if (flaws & FL_SHORT)
      while (msg_bytes.size() > short_len)
        void'(msg_bytes.pop_back());
  endtask

  task automatic drain_results();
    while (awaited_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One random message: half well formed, the rest flawed or pure noise
  task automatic random_message();
    int r;
    int flaws;
    int hi;
    int decl;
    snd_idle_pct = pick_idle();
    rcv_idle_pct = pick_idle();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      msg_bytes.delete();
      repeat ($urandom_range(1, 40))
        msg_bytes.push_back(8'($urandom));
      msg_carrier = 8'($urandom);
    end else begin
      flaws = FL_NONE;
      if (r >= 60) begin
        flaws = 1 << $urandom_range(0, FL_KINDS - 1);
        if ($urandom_range(0, 2) == 0)
          flaws |= 1 << $urandom_range(0, FL_KINDS - 1);
      end
      if (cf_maxlen == 16'd0) begin
        decl = $urandom_range(1, 8);
      end else begin
        hi   = (cf_maxlen < 16'd12) ? int'(cf_maxlen) : 12;
        decl = $urandom_range(1, hi);
        if ($urandom_range(0, 19) == 0 && cf_maxlen <= 16'd200)
          decl = int'(cf_maxlen);
      end
      build_message(flaws, decl, $urandom_range(1, HDR_LEN - 1), FILL_RAND);
    end
    send_message(1'b0, ST_OK);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_word_t w;
    if (!rst && res_if.valid && res_if.ready) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected word, kind", 64'(res_if.kind), 64'd0);
      end else begin
        w = awaited_words.pop_front();
        if (res_if.kind !== w.kind)
          report_mismatch("kind", 64'(res_if.kind), 64'(w.kind));
        if (res_if.body_byte !== w.body)
          report_mismatch("body_byte", 64'(res_if.body_byte), 64'(w.body));
        if (res_if.frame_type !== w.mtype)
          report_mismatch("frame_type", 64'(res_if.frame_type), 64'(w.mtype));
        if (res_if.request_ident !== w.req)
          report_mismatch("request_ident", 64'(res_if.request_ident), 64'(w.req));
        if (res_if.generation !== w.gen)
          report_mismatch("generation", 64'(res_if.generation), 64'(w.gen));
        if (res_if.cookie !== w.cookie)
          report_mismatch("cookie", res_if.cookie, w.cookie);
        if (res_if.body_length !== w.blen)
          report_mismatch("body_length", 64'(res_if.body_length), 64'(w.blen));
        if (res_if.status !== w.status)
          report_mismatch("status", 64'(res_if.status), 64'(w.status));
        if (res_if.last !== w.last)
          report_mismatch("last", 64'(res_if.last), 64'(w.last));
      end
      res_stall = draw_wait(rcv_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (res_stall > 0) begin
      res_if.ready <= 1'b0;
      res_stall--;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase_start;
    rst                  = 1'b1;
    pl_if.valid          = 1'b0;
    pl_if.data_byte      = 8'd0;
    pl_if.end_of_payload = 1'b0;
    pl_if.carrier_type   = 8'd0;
    cfg_if.valid         = 1'b0;
    cfg_if.addr          = CFG_VERSION;
    cfg_if.wdata         = 16'd0;
    res_if.ready         = 1'b0;
    cf_version = 8'd1;
    cf_maxlen  = 16'd1024;
    cf_chan    = 8'd1;
    clear_parser();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed messages at reset settings
    for (int i = 0; i < N_ROWS; i++) begin
      snd_idle_pct = pick_idle();
      rcv_idle_pct = pick_idle();
      build_message(msg_rows[i].flaws, msg_rows[i].decl_len, msg_rows[i].short_len,
                    msg_rows[i].fill);
      send_message(msg_rows[i].typed, msg_rows[i].want);
    end

    // Random messages over several register settings
    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: begin
          write_reg(CFG_VERSION, 16'd0);
          write_reg(CFG_MAX_LEN, 16'd1);
          write_reg(CFG_CHAN, 16'd0);
        end
        1: begin
          write_reg(CFG_VERSION, 16'd255);
          write_reg(CFG_MAX_LEN, 16'hFFFF);
          write_reg(CFG_CHAN, 16'd255);
        end
        2: begin
          // every body length fails; upper data bits of byte registers are junk
          write_reg(CFG_RESERVED, 16'($urandom));
          write_reg(CFG_VERSION, 16'($urandom));
          write_reg(CFG_MAX_LEN, 16'd0);
          write_reg(CFG_CHAN, 16'($urandom));
        end
        default: begin
          write_reg(CFG_VERSION, 16'($urandom));
          write_reg(CFG_MAX_LEN, 16'($urandom_range(1, 300)));
          write_reg(CFG_CHAN, 16'($urandom));
        end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS)
        random_message();
    end

    drain_results();
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mhd_pkg.sv
hdl/mhd_if.sv
hdl/mhd_front.sv
hdl/mhd_queue.sv
hdl/mhd_back.sv
hdl/message_header_deframer_unit.sv
tb/tb_message_header_deframer_unit.sv
